// ===== sv/qebd_pkg.sv =====
// Shared types and constants of the quadrant edge blockage detector.
`default_nettype none

package qebd_pkg;

	localparam int CfgDimW  = 12;
	localparam int CountW   = 21;
	localparam int PartW    = 3;
	localparam int PixelW   = 8;
	localparam int NumQuad  = 4;
	localparam int QuadIdxW = 2;
	localparam int MaskW    = 4;
	localparam int RegAddrW = 2;
	localparam int ApbAddrW = RegAddrW + 2;
	localparam int ApbDataW = 32;

	localparam int DefMaxWidth  = 2048;
	localparam int DefMaxHeight = 2048;

	localparam logic [CfgDimW-1:0] RstFrameWidth       = CfgDimW'(640);
	localparam logic [CfgDimW-1:0] RstFrameHeight      = CfgDimW'(360);
	localparam logic [CountW-1:0]  RstUnblockThreshold = '0;
	localparam logic [PartW-1:0]   RstPartThreshold    = '0;

	localparam logic [CountW-1:0]  CountMax = '1;

	typedef enum logic [RegAddrW-1:0] {
		REG_FRAME_WIDTH       = 2'd0,
		REG_FRAME_HEIGHT      = 2'd1,
		REG_UNBLOCK_THRESHOLD = 2'd2,
		REG_PART_THRESHOLD    = 2'd3
	} reg_addr_t;

	// Where the pixel under work sits in the frame.
	typedef struct packed {
		logic                in_area;
		logic [QuadIdxW-1:0] quad_idx;
		logic                frame_end;
	} pos_info_t;

	typedef logic [NumQuad-1:0][CountW-1:0] count_vec_t;

	typedef struct packed {
		logic                camera_blocked;
		logic [PartW-1:0]    blocked_count;
		logic [MaskW-1:0]    quadrant_mask;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/qebd_position.sv =====
// Column and row tracking of the pixel stream against the configured frame size.
`default_nettype none

module qebd_position import qebd_pkg::*; #(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               start,
	input  wire logic [CfgDimW-1:0] frame_width,
	input  wire logic [CfgDimW-1:0] frame_height,
	output pos_info_t               info
);

	localparam int WDimW = ($clog2(MAX_WIDTH + 1) > CfgDimW) ? $clog2(MAX_WIDTH + 1) : CfgDimW;
	localparam int HDimW = ($clog2(MAX_HEIGHT + 1) > CfgDimW) ? $clog2(MAX_HEIGHT + 1) : CfgDimW;
	localparam int ColW  = $clog2(MAX_WIDTH);
	localparam int RowW  = $clog2(MAX_HEIGHT);

	logic [ColW-1:0]  col_q;
	logic [RowW-1:0]  row_q;
	logic [ColW-1:0]  col_cur;
	logic [RowW-1:0]  row_cur;
	logic [WDimW-1:0] w_raw, w_eff, hw, col_x;
	logic [HDimW-1:0] h_raw, h_eff, hh, row_x;
	logic             row_end;

	// Clamp the frame size to the supported range.
	always_comb begin
		w_raw = WDimW'(frame_width);
		h_raw = HDimW'(frame_height);
		if (w_raw < WDimW'(2)) begin
			w_eff = WDimW'(2);
		end else if (w_raw > WDimW'(MAX_WIDTH)) begin
			w_eff = WDimW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < HDimW'(2)) begin
			h_eff = HDimW'(2);
		end else if (h_raw > HDimW'(MAX_HEIGHT)) begin
			h_eff = HDimW'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
		hw = w_eff >> 1;
		hh = h_eff >> 1;
	end

	always_comb begin
		col_cur = start ? '0 : col_q;
		row_cur = start ? '0 : row_q;
		col_x   = WDimW'(col_cur);
		row_x   = HDimW'(row_cur);
		info.in_area   = (col_x < {w_eff[WDimW-1:1], 1'b0}) &&
			(row_x < {h_eff[HDimW-1:1], 1'b0});
		info.quad_idx  = {col_x >= hw, row_x >= hh};
		row_end        = col_x >= (w_eff - WDimW'(1));
		info.frame_end = row_end && (row_x >= (h_eff - HDimW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (info.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_cur + RowW'(1);
			end else begin
				col_q <= col_cur + ColW'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/qebd_counters.sv =====
// Four saturating edge-pixel counters, one per quadrant.
`default_nettype none

module qebd_counters import qebd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic                start,
	input  wire logic                hit,
	input  wire logic [QuadIdxW-1:0] quad_idx,
	input  wire logic                frame_end,
	output count_vec_t               count_next
);

	count_vec_t count_q;

	always_comb begin
		logic [CountW-1:0] base;
		for (int i = 0; i < NumQuad; i++) begin
			base = start ? '0 : count_q[i];
			if (hit && (quad_idx == QuadIdxW'(i)) && (base != CountMax)) begin
				count_next[i] = base + CountW'(1);
			end else begin
				count_next[i] = base;
			end
		end
	end

	// Clear after the frame's last pixel so the next pixel opens a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= frame_end ? '0 : count_next;
		end
	end

endmodule

`default_nettype wire

// ===== sv/qebd_judge.sv =====
// Threshold compare of the quadrant counts and the camera blocked decision.
`default_nettype none

module qebd_judge import qebd_pkg::*; (
	input  wire count_vec_t         counts,
	input  wire logic [CountW-1:0]  unblock_threshold,
	input  wire logic [PartW-1:0]   part_threshold,
	output result_t                 result
);

	always_comb begin
		logic [PartW-1:0] n;
		n = '0;
		for (int i = 0; i < NumQuad; i++) begin
			result.quadrant_mask[i] = counts[i] < unblock_threshold;
			n = n + PartW'(result.quadrant_mask[i]);
		end
		result.blocked_count  = n;
		result.camera_blocked = n > part_threshold;
	end

endmodule

`default_nettype wire

// ===== sv/quadrant_edge_blockage_detector_unit.sv =====
// Top level of the quadrant edge blockage detector.
//
// Takes one edge-map pixel per transfer in raster order, tracks column and row
// against frame_width x frame_height (clamped to 2..MAX_WIDTH / 2..MAX_HEIGHT)
// and counts nonzero pixels per quadrant; an odd last column or row belongs to
// no quadrant. A pixel with s_tuser set opens a new frame. On the frame's last
// pixel one result leaves on the master side: m_tdata holds the blocked
// quadrant mask (count below unblock_threshold), the number of blocked
// quadrants and the camera blocked flag (that number above part_threshold).
// Other pixels give no output. Rate: one pixel per clock while input is not
// held back (see below); position and counters update in stage s1. m_tvalid
// rises once the frame's last pixel has left the s1 register and its result
// has been loaded into the result register. Input is held back only while a
// finished result waits untaken and the pixel held in s1 ends a frame
// too. Counts saturate at 2^21-1. Registers sit at byte addresses 0, 4, 8, 12
// in list order; write them only while no frame is in flight.
`default_nettype none

module quadrant_edge_blockage_detector_unit import qebd_pkg::*; #(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slave side
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [PixelW-1:0]   s_tdata,   // [7:0] edge_pixel
	input  wire logic                s_tuser,   // [0] frame_start
	// master side
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // [3:0] quadrant_mask, [6:4] blocked_count,
	                                            // [7] camera_blocked
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0]      prdata,
	output logic                     pready
);

	// Configuration registers.
	logic [CfgDimW-1:0] frame_width_q;
	logic [CfgDimW-1:0] frame_height_q;
	logic [CountW-1:0]  unblock_threshold_q;
	logic [PartW-1:0]   part_threshold_q;
	reg_addr_t          reg_sel;
	logic               cfg_write;

	// Stage s1: the accepted pixel.
	logic              valid_s1;
	logic [PixelW-1:0] pixel_s1;
	logic              start_s1;
	logic              advance;
	logic              s_accept;

	// Result register.
	logic    m_valid_q;
	result_t result_q;

	pos_info_t  info;
	count_vec_t count_next;
	result_t    result;

	assign pready    = 1'b1;
	assign reg_sel   = reg_addr_t'(paddr[ApbAddrW-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q       <= RstFrameWidth;
			frame_height_q      <= RstFrameHeight;
			unblock_threshold_q <= RstUnblockThreshold;
			part_threshold_q    <= RstPartThreshold;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:       frame_width_q       <= pwdata[CfgDimW-1:0];
				REG_FRAME_HEIGHT:      frame_height_q      <= pwdata[CfgDimW-1:0];
				REG_UNBLOCK_THRESHOLD: unblock_threshold_q <= pwdata[CountW-1:0];
				REG_PART_THRESHOLD:    part_threshold_q    <= pwdata[PartW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:       prdata = ApbDataW'(frame_width_q);
			REG_FRAME_HEIGHT:      prdata = ApbDataW'(frame_height_q);
			REG_UNBLOCK_THRESHOLD: prdata = ApbDataW'(unblock_threshold_q);
			REG_PART_THRESHOLD:    prdata = ApbDataW'(part_threshold_q);
			default:               prdata = '0;
		endcase
	end

	// Advance s1 unless it ends a frame and the result register is full and not taken.
	assign advance  = valid_s1 && (!info.frame_end || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload until the next transfer.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pixel_s1 <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	qebd_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.start        (start_s1),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.info         (info)
	);

	qebd_counters u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.start      (start_s1),
		.hit        ((pixel_s1 != '0) && info.in_area),
		.quad_idx   (info.quad_idx),
		.frame_end  (info.frame_end),
		.count_next (count_next)
	);

	qebd_judge u_judge (
		.counts            (count_next),
		.unblock_threshold (unblock_threshold_q),
		.part_threshold    (part_threshold_q),
		.result            (result)
	);

	// Load a result on a frame end, drop it once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && info.frame_end) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info.frame_end) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = result_q;

endmodule

`default_nettype wire

// ===== sv/qebd_checker.sv =====
// Port-level checks of the quadrant edge blockage detector and their binding.
`default_nettype none

module qebd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       pready
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The blocked count matches the mask.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:4] == 3'($countones(m_tdata[3:0])))
		else $error("blocked count does not match mask");

	// With no result waiting the input side never stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready && pready)
		else $error("input stalled with empty result register");

	// A new result follows a matching input transfer, registered in s1 and then in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching input transfer");

endmodule

bind quadrant_edge_blockage_detector_unit qebd_checker u_qebd_checker (.*);

`default_nettype wire
